[rtl/bqi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqi_pkg
// Widths, types, output codes and the weight rounding helper shared by the
// biquadratic element interpolator.
// ----------------------------------------------------------------------------
package bqi_pkg;

   localparam int VALUE_BITS      = 32;
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_BITS      = COORD_FRAC_BITS + 2;

   // 1-D weights: signed, WGT_FRAC fraction bits, magnitude below 2^31
   localparam int WGT_FRAC = 28;
   localparam int WGT_BITS = 32;

   // exact 1-D weight before rounding
   localparam int EXACT_BITS = 2 * COORD_BITS + 2;
   localparam int RND_BITS   = EXACT_BITS + WGT_FRAC + 1;
   localparam int K_VAL      = 2 * COORD_FRAC_BITS + 1;
   localparam int K_D1       = COORD_FRAC_BITS + 1;

   // row sums over u
   localparam int PROD_BITS = VALUE_BITS + WGT_BITS;
   localparam int GSUM_BITS = PROD_BITS + 2;
   localparam int CURV_BITS = VALUE_BITS + 3;

   // split of a row sum for the column multipliers
   localparam int LO_BITS       = 32;
   localparam int HI_BITS       = GSUM_BITS - LO_BITS;
   localparam int LO_PROD_BITS  = LO_BITS + 1 + WGT_BITS;
   localparam int HI_PROD_BITS  = HI_BITS + WGT_BITS;
   localparam int UU_PROD_BITS  = CURV_BITS + WGT_BITS;
   localparam int VVS_BITS      = GSUM_BITS + 2;

   // final sums, 2*WGT_FRAC fraction bits
   localparam int ACC_BITS     = GSUM_BITS + WGT_BITS + 2;
   localparam int SUM_SHIFT    = 2 * WGT_FRAC;
   localparam int ACC_RND_BITS = ACC_BITS + 1;
   localparam int SH_BITS      = ACC_RND_BITS - SUM_SHIFT;
   localparam int OUT_BITS     = 40;

   localparam int STAGES  = 6;
   localparam int N_OUTS  = 6;

   // result slots
   localparam int OUT_VALUE = 0;
   localparam int OUT_DU    = 1;
   localparam int OUT_DV    = 2;
   localparam int OUT_UU    = 3;
   localparam int OUT_UV    = 4;
   localparam int OUT_VV    = 5;

   typedef logic signed [VALUE_BITS-1:0]   value_type;
   typedef logic signed [COORD_BITS-1:0]   coord_type;
   typedef logic signed [WGT_BITS-1:0]     wgt_type;
   typedef logic signed [EXACT_BITS-1:0]   exact_type;
   typedef logic signed [PROD_BITS-1:0]    prod_type;
   typedef logic signed [GSUM_BITS-1:0]    gsum_type;
   typedef logic signed [CURV_BITS-1:0]    curv_type;
   typedef logic signed [ACC_BITS-1:0]     acc_type;
   typedef logic signed [OUT_BITS-1:0]     out_type;

   localparam out_type OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam out_type OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   // Rescale an exact weight with k fraction bits to WGT_FRAC bits,
   // rounding half up when bits are dropped.
   function automatic wgt_type round_wgt(input exact_type x, input int k);
      logic signed [RND_BITS-1:0] t;
      logic signed [RND_BITS-1:0] h;
      int sr;
      int sl;
      sr = (k > WGT_FRAC) ? k - WGT_FRAC : 0;
      sl = (k > WGT_FRAC) ? 0 : WGT_FRAC - k;
      h = '0;
      if (sr > 0) begin
         h[sr-1] = 1'b1;
      end
      t = RND_BITS'(x) + h;
      t = (t >>> sr) <<< sl;
      return WGT_BITS'(t);
   endfunction

endpackage
`default_nettype wire

[rtl/bqi_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqi_if
// Valid/ready channels for the interpolator: request (nodes and point) and
// response (value, partials and saturation flag).
// ----------------------------------------------------------------------------
interface bqi_req_if import bqi_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type node_value_0;
   value_type node_value_1;
   value_type node_value_2;
   value_type node_value_3;
   value_type node_value_4;
   value_type node_value_5;
   value_type node_value_6;
   value_type node_value_7;
   value_type node_value_8;
   coord_type coord_u;
   coord_type coord_v;

   modport source (output valid, node_value_0, node_value_1, node_value_2,
                   node_value_3, node_value_4, node_value_5, node_value_6,
                   node_value_7, node_value_8, coord_u, coord_v,
                   input ready);
   modport sink   (input valid, node_value_0, node_value_1, node_value_2,
                   node_value_3, node_value_4, node_value_5, node_value_6,
                   node_value_7, node_value_8, coord_u, coord_v,
                   output ready);
endinterface

interface bqi_rsp_if import bqi_pkg::*; ();
   logic    valid;
   logic    ready;
   out_type interp_value;
   out_type deriv_u;
   out_type deriv_v;
   out_type deriv_uu;
   out_type deriv_uv;
   out_type deriv_vv;
   logic    saturated;

   modport source (output valid, interp_value, deriv_u, deriv_v, deriv_uu,
                   deriv_uv, deriv_vv, saturated, input ready);
   modport sink   (input valid, interp_value, deriv_u, deriv_v, deriv_uu,
                   deriv_uv, deriv_vv, saturated, output ready);
endinterface
`default_nettype wire

[rtl/bqi_axis_weights.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqi_axis_weights
// Quadratic Lagrange weights and their first derivatives on one axis,
// rounded to WGT_FRAC fraction bits and registered.
// ----------------------------------------------------------------------------
module bqi_axis_weights import bqi_pkg::*; (
   input  wire logic clock,
   input  wire logic en,
   input  coord_type coord,
   output wgt_type   val_ff [3],
   output wgt_type   d1_ff  [3]
);

   localparam exact_type SCALE = exact_type'(1) <<< COORD_FRAC_BITS;

   exact_type cx;
   exact_type e_val [3];
   exact_type e_d1  [3];
   wgt_type   val_in [3];
   wgt_type   d1_in  [3];

   always_comb begin
      cx       = EXACT_BITS'(coord);
      e_val[0] = cx * (cx - SCALE);
      e_val[1] = (SCALE * SCALE - cx * cx) <<< 1;
      e_val[2] = cx * (cx + SCALE);
      e_d1[0]  = (cx <<< 1) - SCALE;
      e_d1[1]  = -(cx <<< 2);
      e_d1[2]  = (cx <<< 1) + SCALE;
      for (int i = 0; i < 3; i++) begin
         val_in[i] = round_wgt(e_val[i], K_VAL);
         d1_in[i]  = round_wgt(e_d1[i], K_D1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff <= val_in;
         d1_ff  <= d1_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bqi_row_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqi_row_sum
// One row of three nodes weighted along u: value, slope and curvature sums.
// Two stages: products, then the three-term sums.
// ----------------------------------------------------------------------------
module bqi_row_sum import bqi_pkg::*; (
   input  wire logic clock,
   input  wire logic en,
   input  value_type f   [3],
   input  wgt_type   wv  [3],
   input  wgt_type   wd  [3],
   output gsum_type  g0_ff,
   output gsum_type  g1_ff,
   output curv_type  g2_ff
);

   prod_type  p0_ff [3];
   prod_type  p1_ff [3];
   prod_type  p0_in [3];
   prod_type  p1_in [3];
   value_type f_ff  [3];
   gsum_type  g0_in;
   gsum_type  g1_in;
   curv_type  g2_in;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         p0_in[a] = f[a] * wv[a];
         p1_in[a] = f[a] * wd[a];
      end
      g0_in = GSUM_BITS'(p0_ff[0]) + GSUM_BITS'(p0_ff[1]) + GSUM_BITS'(p0_ff[2]);
      g1_in = GSUM_BITS'(p1_ff[0]) + GSUM_BITS'(p1_ff[1]) + GSUM_BITS'(p1_ff[2]);
      // second difference; the constant second-derivative weight is applied later
      g2_in = CURV_BITS'(f_ff[0]) - (CURV_BITS'(f_ff[1]) <<< 1) + CURV_BITS'(f_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         f_ff  <= f;
         g0_ff <= g0_in;
         g1_ff <= g1_in;
         g2_ff <= g2_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bqi_col_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqi_col_sum
// Combines the three row sums with the v weights into the six exact sums.
// Two stages: split partial products, then the wide additions.
// ----------------------------------------------------------------------------
module bqi_col_sum import bqi_pkg::*; (
   input  wire logic clock,
   input  wire logic en,
   input  gsum_type  g0 [3],
   input  gsum_type  g1 [3],
   input  curv_type  g2 [3],
   input  wgt_type   lv [3],
   input  wgt_type   dv [3],
   output acc_type   acc_ff [N_OUTS]
);

   // products of (u sum, v weight): g0*lv, g1*lv, g0*dv, g1*dv
   localparam int PAIR_OUT [4] = '{OUT_VALUE, OUT_DU, OUT_DV, OUT_UV};

   gsum_type                    gsel  [4][3];
   wgt_type                     wsel  [4][3];
   logic signed [LO_BITS:0]     lo_op [4][3];
   logic signed [HI_BITS-1:0]   hi_op [4][3];
   logic signed [LO_PROD_BITS-1:0] plo_in [4][3];
   logic signed [LO_PROD_BITS-1:0] plo_ff [4][3];
   logic signed [HI_PROD_BITS-1:0] phi_in [4][3];
   logic signed [HI_PROD_BITS-1:0] phi_ff [4][3];
   logic signed [UU_PROD_BITS-1:0] puu_in [3];
   logic signed [UU_PROD_BITS-1:0] puu_ff [3];
   logic signed [VVS_BITS-1:0]     vvs_in;
   logic signed [VVS_BITS-1:0]     vvs_ff;
   acc_type                        acc_in [N_OUTS];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int b = 0; b < 3; b++) begin
            gsel[k][b]   = k[0] ? g1[b] : g0[b];
            wsel[k][b]   = k[1] ? dv[b] : lv[b];
            lo_op[k][b]  = {1'b0, gsel[k][b][LO_BITS-1:0]};
            hi_op[k][b]  = gsel[k][b][GSUM_BITS-1:LO_BITS];
            plo_in[k][b] = lo_op[k][b] * wsel[k][b];
            phi_in[k][b] = hi_op[k][b] * wsel[k][b];
         end
      end
      for (int b = 0; b < 3; b++) begin
         puu_in[b] = g2[b] * lv[b];
      end
      vvs_in = VVS_BITS'(g0[0]) - (VVS_BITS'(g0[1]) <<< 1) + VVS_BITS'(g0[2]);

      for (int q = 0; q < N_OUTS; q++) begin
         acc_in[q] = '0;
      end
      for (int k = 0; k < 4; k++) begin
         for (int b = 0; b < 3; b++) begin
            acc_in[PAIR_OUT[k]] = acc_in[PAIR_OUT[k]]
                                + (ACC_BITS'(phi_ff[k][b]) <<< LO_BITS)
                                + ACC_BITS'(plo_ff[k][b]);
         end
      end
      for (int b = 0; b < 3; b++) begin
         acc_in[OUT_UU] = acc_in[OUT_UU] + (ACC_BITS'(puu_ff[b]) <<< WGT_FRAC);
      end
      acc_in[OUT_VV] = ACC_BITS'(vvs_ff) <<< WGT_FRAC;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         puu_ff <= puu_in;
         vvs_ff <= vvs_in;
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bqi_round_sat.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqi_round_sat
// Rounds one exact sum to value units (half up) and clips it to the
// signed output range, flagging a clip.
// ----------------------------------------------------------------------------
module bqi_round_sat import bqi_pkg::*; (
   input  wire logic clock,
   input  wire logic en,
   input  acc_type   acc,
   output out_type   value_ff,
   output logic      sat_ff
);

   localparam logic signed [ACC_RND_BITS-1:0] HALF =
      ACC_RND_BITS'(1) <<< (SUM_SHIFT - 1);
   localparam logic signed [SH_BITS-1:0] SMAX = SH_BITS'(OUT_MAX);
   localparam logic signed [SH_BITS-1:0] SMIN = SH_BITS'(OUT_MIN);

   logic signed [ACC_RND_BITS-1:0] t;
   logic signed [SH_BITS-1:0]      sh;
   out_type                        value_in;
   logic                           sat_in;

   always_comb begin
      t  = ACC_RND_BITS'(acc) + HALF;
      sh = SH_BITS'(t >>> SUM_SHIFT);
      priority if (sh > SMAX) begin
         value_in = OUT_MAX;
         sat_in   = 1'b1;
      end else if (sh < SMIN) begin
         value_in = OUT_MIN;
         sat_in   = 1'b1;
      end else begin
         value_in = OUT_BITS'(sh);
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

endmodule
`default_nettype wire

[rtl/biquadratic_element_interpolator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquadratic_element_interpolator_unit
// Q9 element interpolation: value, first and second partials at (u,v).
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the output stalls; outputs are Q24.16
// for Q16.16 nodes. The six register stages are: axis weights, u-weighted
// products, row sums, v-weighted partial products, column sums, and
// rounding with saturation. The pipeline advances as one whenever the output
// slot is empty or being taken, so a stalled response holds every stage in
// place. Past weight rounding, arithmetic is exact to the final rounding.
module biquadratic_element_interpolator_unit import bqi_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bqi_req_if.sink   req_ch,
   bqi_rsp_if.source rsp_ch
);

   logic              en;
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;

   value_type node_ff [9];
   value_type row_f   [3][3];
   wgt_type   lu [3];
   wgt_type   du [3];
   wgt_type   lv [3];
   wgt_type   dv [3];
   wgt_type   lv_s2_ff [3];
   wgt_type   dv_s2_ff [3];
   wgt_type   lv_s3_ff [3];
   wgt_type   dv_s3_ff [3];
   gsum_type  g0 [3];
   gsum_type  g1 [3];
   curv_type  g2 [3];
   acc_type   acc [N_OUTS];
   out_type   res [N_OUTS];
   logic [N_OUTS-1:0] sat;

   assign en           = !vld_ff[STAGES-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign vld_in       = {vld_ff[STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         node_ff[0] <= req_ch.node_value_0;
         node_ff[1] <= req_ch.node_value_1;
         node_ff[2] <= req_ch.node_value_2;
         node_ff[3] <= req_ch.node_value_3;
         node_ff[4] <= req_ch.node_value_4;
         node_ff[5] <= req_ch.node_value_5;
         node_ff[6] <= req_ch.node_value_6;
         node_ff[7] <= req_ch.node_value_7;
         node_ff[8] <= req_ch.node_value_8;
         lv_s2_ff   <= lv;
         dv_s2_ff   <= dv;
         lv_s3_ff   <= lv_s2_ff;
         dv_s3_ff   <= dv_s2_ff;
      end
   end

   bqi_axis_weights u_axis_u (
      .clock  (clock),
      .en     (en),
      .coord  (req_ch.coord_u),
      .val_ff (lu),
      .d1_ff  (du)
   );

   bqi_axis_weights u_axis_v (
      .clock  (clock),
      .en     (en),
      .coord  (req_ch.coord_v),
      .val_ff (lv),
      .d1_ff  (dv)
   );

   // rows by v position, columns by u position (-1, 0, +1)
   always_comb begin
      row_f[0][0] = node_ff[0];
      row_f[0][1] = node_ff[4];
      row_f[0][2] = node_ff[1];
      row_f[1][0] = node_ff[7];
      row_f[1][1] = node_ff[8];
      row_f[1][2] = node_ff[5];
      row_f[2][0] = node_ff[3];
      row_f[2][1] = node_ff[6];
      row_f[2][2] = node_ff[2];
   end

   for (genvar b = 0; b < 3; b++) begin : g_row
      bqi_row_sum u_row (
         .clock (clock),
         .en    (en),
         .f     (row_f[b]),
         .wv    (lu),
         .wd    (du),
         .g0_ff (g0[b]),
         .g1_ff (g1[b]),
         .g2_ff (g2[b])
      );
   end

   bqi_col_sum u_col (
      .clock  (clock),
      .en     (en),
      .g0     (g0),
      .g1     (g1),
      .g2     (g2),
      .lv     (lv_s3_ff),
      .dv     (dv_s3_ff),
      .acc_ff (acc)
   );

   for (genvar q = 0; q < N_OUTS; q++) begin : g_out
      bqi_round_sat u_rnd (
         .clock    (clock),
         .en       (en),
         .acc      (acc[q]),
         .value_ff (res[q]),
         .sat_ff   (sat[q])
      );
   end

   assign rsp_ch.valid        = vld_ff[STAGES-1];
   assign rsp_ch.interp_value = res[OUT_VALUE];
   assign rsp_ch.deriv_u      = res[OUT_DU];
   assign rsp_ch.deriv_v      = res[OUT_DV];
   assign rsp_ch.deriv_uu     = res[OUT_UU];
   assign rsp_ch.deriv_uv     = res[OUT_UV];
   assign rsp_ch.deriv_vv     = res[OUT_VV];
   assign rsp_ch.saturated    = |sat;

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> vld_ff == '0)
      else $error("pipeline not empty after reset");

   // a held result freezes every stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   // a pending result blocks new items
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("item taken while output stalled");

   // a clip leaves some field at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturated |->
         (res[OUT_VALUE] == OUT_MAX || res[OUT_VALUE] == OUT_MIN ||
          res[OUT_DU] == OUT_MAX || res[OUT_DU] == OUT_MIN ||
          res[OUT_DV] == OUT_MAX || res[OUT_DV] == OUT_MIN ||
          res[OUT_UU] == OUT_MAX || res[OUT_UU] == OUT_MIN ||
          res[OUT_UV] == OUT_MAX || res[OUT_UV] == OUT_MIN ||
          res[OUT_VV] == OUT_MAX || res[OUT_VV] == OUT_MIN))
      else $error("saturation flag without clipped field");

endmodule
`default_nettype wire
